// ----- design/geo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_pkg
// shared widths, constants, the cell payload type and the base32 alphabet
// ----------------------------------------------------------------------------
package geo_pkg;

  localparam int FRACTION_BITS     = 23;
  localparam int MAX_BITS_PER_AXIS = 25;

  // fixed field widths
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int CFG_W  = 5;
  localparam int CHAR_W = 7;
  localparam int IDX_W  = 4;
  localparam int SYM_W  = 5;

  localparam logic [CFG_W-1:0] BPA_RESET = CFG_W'(20);
  localparam logic [CFG_W-1:0] BPA_MAX   = CFG_W'(MAX_BITS_PER_AXIS);

  // axis ranges in fixed point
  localparam longint LAT_HALF = 90 * (longint'(1) << FRACTION_BITS);
  localparam longint LON_HALF = 180 * (longint'(1) << FRACTION_BITS);
  localparam longint LAT_SPAN = 2 * LAT_HALF;
  localparam longint LON_SPAN = 2 * LON_HALF;

  // remainder width: holds anything below the larger span
  localparam int REM_W  = $clog2(LON_SPAN);
  // signed width for clamping, wide enough for the inputs and the offsets
  localparam int WIDE_W = ((LON_W > REM_W + 1) ? LON_W : REM_W + 1) + 1;

  localparam logic signed [WIDE_W-1:0] LAT_MIN = WIDE_W'(-LAT_HALF);
  localparam logic signed [WIDE_W-1:0] LAT_MAX = WIDE_W'(LAT_HALF - 1);
  localparam logic signed [WIDE_W-1:0] LAT_OFS = WIDE_W'(LAT_HALF);
  localparam logic signed [WIDE_W-1:0] LON_MIN = WIDE_W'(-LON_HALF);
  localparam logic signed [WIDE_W-1:0] LON_MAX = WIDE_W'(LON_HALF - 1);
  localparam logic signed [WIDE_W-1:0] LON_OFS = WIDE_W'(LON_HALF);

  localparam logic [REM_W:0] LAT_SPAN_X = (REM_W + 1)'(LAT_SPAN);
  localparam logic [REM_W:0] LON_SPAN_X = (REM_W + 1)'(LON_SPAN);

  // interleaved bit word at full precision, and the characters it holds
  localparam int WORD_W    = 2 * MAX_BITS_PER_AXIS;
  localparam int MAX_CHARS = (2 * MAX_BITS_PER_AXIS) / 5;

  typedef struct packed {
    logic                 valid;
    logic [REM_W-1:0]     lat_rem;
    logic [REM_W-1:0]     lon_rem;
    logic [WORD_W-1:0]    word;
    logic [IDX_W-1:0]     count;
  } cell_t;

  // characters per hash = floor(2n / 5), via 410/1024 for n up to 25
  function automatic logic [IDX_W-1:0] char_count(input logic [CFG_W-1:0] n);
    logic [CFG_W+8:0] prod;
    prod = (CFG_W + 9)'(n) * (CFG_W + 9)'(410);
    return IDX_W'(prod >> 10);
  endfunction

  function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] sym);
    logic [CHAR_W-1:0] c;
    case (sym)
      5'd0:  c = 7'h30;  // 0
      5'd1:  c = 7'h31;
      5'd2:  c = 7'h32;
      5'd3:  c = 7'h33;
      5'd4:  c = 7'h34;
      5'd5:  c = 7'h35;
      5'd6:  c = 7'h36;
      5'd7:  c = 7'h37;
      5'd8:  c = 7'h38;
      5'd9:  c = 7'h39;  // 9
      5'd10: c = 7'h62;  // b
      5'd11: c = 7'h63;
      5'd12: c = 7'h64;
      5'd13: c = 7'h65;
      5'd14: c = 7'h66;
      5'd15: c = 7'h67;  // g
      5'd16: c = 7'h68;  // h
      5'd17: c = 7'h6a;  // j
      5'd18: c = 7'h6b;  // k
      5'd19: c = 7'h6d;  // m
      5'd20: c = 7'h6e;  // n
      5'd21: c = 7'h70;  // p
      5'd22: c = 7'h71;
      5'd23: c = 7'h72;
      5'd24: c = 7'h73;
      5'd25: c = 7'h74;
      5'd26: c = 7'h75;
      5'd27: c = 7'h76;
      5'd28: c = 7'h77;
      5'd29: c = 7'h78;
      5'd30: c = 7'h79;
      5'd31: c = 7'h7a;  // z
      default: c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

// ----- design/geohash_encoder.sv -----
`timescale 1ns / 1ps
// path: a request accepted into the clamp stage passes 25 bisection cells and
//   the output register before its first character shows; the chain can stall
// throughput: set by the single output port, which gives out a hash's characters
//   (up to 10) one after another; one request per cycle when a hash has no characters
// reset: rst_n synchronous active low, empties the chain and the output,
//   bits_per_axis returns to 20
// ----------------------------------------------------------------------------
// geohash_encoder
// latitude/longitude to base32 geohash, one character per output request
// ----------------------------------------------------------------------------
module geohash_encoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic        [geo_pkg::CFG_W-1:0]     cfg_wdata,
  // coordinate requests
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [geo_pkg::LAT_W-1:0]     in_latitude,
  input  logic signed [geo_pkg::LON_W-1:0]     in_longitude,
  // character requests
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [geo_pkg::CHAR_W-1:0]    out_hash_char,
  output logic        [geo_pkg::IDX_W-1:0]     out_char_index,
  output logic                                 out_last
);

  localparam int NCELL = geo_pkg::MAX_BITS_PER_AXIS;

  // precision register
  logic [geo_pkg::CFG_W-1:0] bpa_r, bpa_nxt;

  // chain taps: stage 0 is the clamp stage, stage NCELL the last cell
  geo_pkg::cell_t chain [0:NCELL];
  logic           ser_free;
  logic           adv;

  assign bpa_nxt = cfg_we ? cfg_wdata : bpa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpa_r <= geo_pkg::BPA_RESET;
    end else begin
      bpa_r <= bpa_nxt;
    end
  end

  // the whole chain moves together; it only holds when the last cell carries
  // characters that the output register cannot take this cycle. a request
  // with no characters (precision below 3) simply falls off the end
  assign adv = !chain[NCELL].valid || (chain[NCELL].count == '0) || ser_free;
  assign in_ready = adv;

  geo_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .latitude      (in_latitude),
    .longitude     (in_longitude),
    .bits_per_axis (bpa_r),
    .front         (chain[0])
  );

  // every request goes through all steps at full precision; the first
  // floor(2n/5) characters of that hash equal the hash at precision n
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    geo_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .cin   (chain[i]),
      .cout  (chain[i+1])
    );
  end

  // output register and character shifter
  geo_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .sin            (chain[NCELL]),
    .free           (ser_free),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_char  (out_hash_char),
    .out_char_index (out_char_index),
    .out_last       (out_last)
  );

`ifndef ASSERT_OFF
  // a full last cell with characters must stall the chain if output is busy
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (chain[NCELL].valid && (chain[NCELL].count != '0) && !ser_free) |-> !in_ready)
    else $error("chain advanced while output register was full");

  // characters of one hash come out with consecutive indexes
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=>
      (out_valid && (out_char_index == geo_pkg::IDX_W'($past(out_char_index) + 1'b1))))
    else $error("character index did not advance by one");

  // index never passes the longest hash
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_index < geo_pkg::IDX_W'(geo_pkg::MAX_CHARS)))
    else $error("character index out of range");

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ----- design/geo_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_front
// clamps both coordinates, forms offsets from the range minimum, sets count
// ----------------------------------------------------------------------------
module geo_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  in_valid,
  input  logic signed [geo_pkg::LAT_W-1:0]      latitude,
  input  logic signed [geo_pkg::LON_W-1:0]      longitude,
  input  logic        [geo_pkg::CFG_W-1:0]      bits_per_axis,
  output geo_pkg::cell_t                        front
);

  logic signed [geo_pkg::WIDE_W-1:0] lat_s, lon_s, lat_c, lon_c, lat_o, lon_o;
  logic        [geo_pkg::CFG_W-1:0]  n_eff;

  logic                              valid_r;
  geo_pkg::cell_t                    data_r, data_nxt;

  assign lat_s = geo_pkg::WIDE_W'(latitude);
  assign lon_s = geo_pkg::WIDE_W'(longitude);

  // upper edge maps to span - 1, which still yields all ones
  always_comb begin
    if (lat_s < geo_pkg::LAT_MIN) begin
      lat_c = geo_pkg::LAT_MIN;
    end else if (lat_s > geo_pkg::LAT_MAX) begin
      lat_c = geo_pkg::LAT_MAX;
    end else begin
      lat_c = lat_s;
    end
    if (lon_s < geo_pkg::LON_MIN) begin
      lon_c = geo_pkg::LON_MIN;
    end else if (lon_s > geo_pkg::LON_MAX) begin
      lon_c = geo_pkg::LON_MAX;
    end else begin
      lon_c = lon_s;
    end
  end

  assign lat_o = lat_c + geo_pkg::LAT_OFS;
  assign lon_o = lon_c + geo_pkg::LON_OFS;
  assign n_eff = (bits_per_axis > geo_pkg::BPA_MAX) ? geo_pkg::BPA_MAX : bits_per_axis;

  always_comb begin
    data_nxt         = '0;
    data_nxt.lat_rem = lat_o[geo_pkg::REM_W-1:0];
    data_nxt.lon_rem = lon_o[geo_pkg::REM_W-1:0];
    data_nxt.count   = geo_pkg::char_count(n_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    front       = data_r;
    front.valid = valid_r;
  end

endmodule

// ----- design/geo_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_cell
// one bisection step on both axes, appends lon and lat bits to the word
// ----------------------------------------------------------------------------
module geo_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  geo_pkg::cell_t cin,
  output geo_pkg::cell_t cout
);

  logic [geo_pkg::REM_W:0] lat2, lon2, lat_d, lon_d;
  logic                    lat_bit, lon_bit;
  logic                    valid_r;
  geo_pkg::cell_t          data_r, data_nxt;

  assign lat2    = {cin.lat_rem, 1'b0};
  assign lon2    = {cin.lon_rem, 1'b0};
  assign lat_bit = (lat2 >= geo_pkg::LAT_SPAN_X);
  assign lon_bit = (lon2 >= geo_pkg::LON_SPAN_X);
  assign lat_d   = lat2 - geo_pkg::LAT_SPAN_X;
  assign lon_d   = lon2 - geo_pkg::LON_SPAN_X;

  always_comb begin
    data_nxt         = cin;
    data_nxt.lat_rem = lat_bit ? lat_d[geo_pkg::REM_W-1:0] : lat2[geo_pkg::REM_W-1:0];
    data_nxt.lon_rem = lon_bit ? lon_d[geo_pkg::REM_W-1:0] : lon2[geo_pkg::REM_W-1:0];
    data_nxt.word    = {cin.word[geo_pkg::WORD_W-3:0], lon_bit, lat_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= cin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    cout       = data_r;
    cout.valid = valid_r;
  end

endmodule

// ----- design/geo_ser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geo_ser
// output register, shifts out one base32 character per accepted cycle
// ----------------------------------------------------------------------------
module geo_ser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  geo_pkg::cell_t                sin,
  output logic                          free,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [geo_pkg::CHAR_W-1:0]    out_hash_char,
  output logic [geo_pkg::IDX_W-1:0]     out_char_index,
  output logic                          out_last
);

  logic                         busy_r, busy_nxt;
  logic [geo_pkg::WORD_W-1:0]   word_r, word_nxt;
  logic [geo_pkg::IDX_W-1:0]    idx_r, idx_nxt;
  logic [geo_pkg::IDX_W-1:0]    cnt_r, cnt_nxt;
  logic                         is_last, take, load;

  assign is_last = (geo_pkg::IDX_W'(idx_r + 1'b1) == cnt_r);
  assign take    = busy_r && out_ready;
  assign free    = !busy_r || (out_ready && is_last);
  assign load    = sin.valid && (sin.count != '0) && free;

  always_comb begin
    busy_nxt = busy_r;
    word_nxt = word_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      word_nxt = sin.word;
      idx_nxt  = '0;
      cnt_nxt  = sin.count;
    end else if (take) begin
      if (is_last) begin
        busy_nxt = 1'b0;
      end else begin
        word_nxt = word_r << geo_pkg::SYM_W;
        idx_nxt  = geo_pkg::IDX_W'(idx_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign out_valid      = busy_r;
  assign out_hash_char  = geo_pkg::sym_to_char(
                            word_r[geo_pkg::WORD_W-1 -: geo_pkg::SYM_W]);
  assign out_char_index = idx_r;
  assign out_last       = is_last;

endmodule
